// ===== src/vcld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcld_pkg: shared types and constants of the vector command line drawer
// Request and response words, decoded operation codes and queue status.
// ----------------------------------------------------------------------------
package vcld_pkg;

	localparam int SCREEN_WIDTH_DEF  = 200;
	localparam int SCREEN_HEIGHT_DEF = 200;

	localparam logic [7:0] OPCODE_VECTOR = 8'd89;
	localparam logic [7:0] STATUS_READY  = 8'hFF;
	localparam logic [7:0] STATUS_BUSY   = 8'h00;

	localparam logic [2:0] REQ_RD_STATUS = 3'd0;
	localparam logic [2:0] REQ_RD_DATA   = 3'd1;
	localparam logic [2:0] REQ_WR_CTRL   = 3'd2;
	localparam logic [2:0] REQ_WR_DATA   = 3'd3;
	localparam logic [2:0] REQ_TICK      = 3'd4;

	localparam logic [2:0] OP_NONE      = 3'd0;
	localparam logic [2:0] OP_STATUS    = 3'd1;
	localparam logic [2:0] OP_DATA_RD   = 3'd2;
	localparam logic [2:0] OP_CTRL_WR   = 3'd3;
	localparam logic [2:0] OP_DATA_WR   = 3'd4;
	localparam logic [2:0] OP_TICK      = 3'd5;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] write_data;
	} req_word_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       pixel_valid;
		logic [7:0] pixel_x;
		logic [7:0] pixel_y;
		logic       busy_res;
	} rsp_word_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic valid_s1;
	} front_stat_t;

endpackage

// ===== src/vcld_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcld_front: request intake and decode
// Accepts request words, decodes the request type and holds one decoded
// command until the queue takes it.
// ----------------------------------------------------------------------------
module vcld_front
	import vcld_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_word_t   req_word,
	input  q_stat_t     q_stat,
	output logic        push,
	output cmd_t        push_cmd,
	output front_stat_t front_stat
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_dec;
	logic take;

	always_comb begin
		cmd_dec.data = req_word.write_data;
		unique case (req_word.req_type)
			REQ_RD_STATUS: cmd_dec.op = OP_STATUS;
			REQ_RD_DATA:   cmd_dec.op = OP_DATA_RD;
			REQ_WR_CTRL:   cmd_dec.op = OP_CTRL_WR;
			REQ_WR_DATA:   cmd_dec.op = OP_DATA_WR;
			REQ_TICK:      cmd_dec.op = OP_TICK;
			default:       cmd_dec.op = OP_NONE;
		endcase
	end

	assign push      = valid_s1 && !q_stat.full;
	assign req_ready = !valid_s1 || !q_stat.full;
	assign take      = req_valid && req_ready;
	assign push_cmd  = cmd_s1;

	assign front_stat.valid_s1 = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_dec;
		end
	end

endmodule

// ===== src/vcld_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcld_queue: command queue
// Short first-in first-out store of decoded commands between decode and
// execution.
// ----------------------------------------------------------------------------
module vcld_queue
	import vcld_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    pop_cmd,
	output q_stat_t q_stat
);

	cmd_t                  mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;

	assign q_stat.full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_cmd      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== src/vcld_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcld_back: command execution and line walk
// Parses the vector command, runs the four-connected line walk one pixel per
// tick and registers one response word per command.
// ----------------------------------------------------------------------------
module vcld_back
	import vcld_pkg::*;
#(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  q_stat_t   q_stat,
	input  cmd_t      pop_cmd,
	output logic      pop,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_word_t rsp_word
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_X0   = 3'd1;
	localparam logic [2:0] PH_Y0   = 3'd2;
	localparam logic [2:0] PH_X1   = 3'd3;
	localparam logic [2:0] PH_Y1   = 3'd4;

	logic [2:0]        phase_q, phase_d;
	logic [7:0]        start_x_q, start_x_d;
	logic [7:0]        start_y_q, start_y_d;
	logic [7:0]        end_x_q, end_x_d;
	logic [7:0]        end_y_q, end_y_d;
	logic [7:0]        walk_x_q, walk_x_d;
	logic [7:0]        walk_y_q, walk_y_d;
	logic [7:0]        span_x_q, span_x_d;
	logic [7:0]        span_y_q, span_y_d;
	logic              neg_x_q, neg_x_d;
	logic              neg_y_q, neg_y_d;
	logic signed [9:0] err_q, err_d;
	logic              drawing_q, drawing_d;

	logic              rsp_valid_q;
	rsp_word_t         rsp_word_q;
	rsp_word_t         rsp_d;
	logic              on_screen;
	logic              at_end;
	logic              neg_y_new;

	assign pop       = !q_stat.empty && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

	assign on_screen = ({1'b0, walk_x_q} < 9'(SCREEN_WIDTH))
		&& ({1'b0, walk_y_q} < 9'(SCREEN_HEIGHT));
	assign at_end    = (walk_x_q == end_x_q) && (walk_y_q == end_y_q);
	assign neg_y_new = pop_cmd.data < start_y_q;

	always_comb begin
		phase_d   = phase_q;
		start_x_d = start_x_q;
		start_y_d = start_y_q;
		end_x_d   = end_x_q;
		end_y_d   = end_y_q;
		walk_x_d  = walk_x_q;
		walk_y_d  = walk_y_q;
		span_x_d  = span_x_q;
		span_y_d  = span_y_q;
		neg_x_d   = neg_x_q;
		neg_y_d   = neg_y_q;
		err_d     = err_q;
		drawing_d = drawing_q;
		rsp_d     = '0;

		unique case (pop_cmd.op)
			OP_STATUS: begin
				rsp_d.read_data = drawing_q ? STATUS_BUSY : STATUS_READY;
			end
			OP_CTRL_WR: begin
				if (!drawing_q) begin
					phase_d = PH_IDLE;
				end
			end
			OP_DATA_WR: begin
				if (!drawing_q) begin
					unique case (phase_q)
						PH_IDLE: begin
							if (pop_cmd.data == OPCODE_VECTOR) begin
								phase_d = PH_X0;
							end
						end
						PH_X0: begin
							start_x_d = pop_cmd.data;
							phase_d   = PH_Y0;
						end
						PH_Y0: begin
							start_y_d = pop_cmd.data;
							phase_d   = PH_X1;
						end
						PH_X1: begin
							end_x_d = pop_cmd.data;
							phase_d = PH_Y1;
						end
						PH_Y1: begin
							end_y_d   = pop_cmd.data;
							phase_d   = PH_IDLE;
							walk_x_d  = start_x_q;
							walk_y_d  = start_y_q;
							neg_x_d   = end_x_q < start_x_q;
							neg_y_d   = neg_y_new;
							span_x_d  = (end_x_q < start_x_q) ? start_x_q - end_x_q
								: end_x_q - start_x_q;
							span_y_d  = neg_y_new ? start_y_q - pop_cmd.data
								: pop_cmd.data - start_y_q;
							err_d     = (end_x_q == start_x_q) ? -10'sd1 : 10'sd0;
							drawing_d = 1'b1;
						end
						default: begin
							phase_d = PH_IDLE;
						end
					endcase
				end
			end
			OP_TICK: begin
				if (drawing_q) begin
					if (on_screen) begin
						rsp_d.pixel_valid = 1'b1;
						rsp_d.pixel_x     = walk_x_q;
						rsp_d.pixel_y     = walk_y_q;
					end
					if (at_end) begin
						drawing_d = 1'b0;
					end else if (err_q < 0) begin
						walk_y_d = neg_y_q ? walk_y_q - 1'b1 : walk_y_q + 1'b1;
						err_d    = err_q + $signed({2'b00, span_x_q});
					end else begin
						walk_x_d = neg_x_q ? walk_x_q - 1'b1 : walk_x_q + 1'b1;
						err_d    = err_q - $signed({2'b00, span_y_q});
					end
				end
			end
			default: begin
			end
		endcase

		rsp_d.busy_res = drawing_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			start_x_q   <= '0;
			start_y_q   <= '0;
			end_x_q     <= '0;
			end_y_q     <= '0;
			walk_x_q    <= '0;
			walk_y_q    <= '0;
			span_x_q    <= '0;
			span_y_q    <= '0;
			neg_x_q     <= 1'b0;
			neg_y_q     <= 1'b0;
			err_q       <= '0;
			drawing_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q   <= phase_d;
				start_x_q <= start_x_d;
				start_y_q <= start_y_d;
				end_x_q   <= end_x_d;
				end_y_q   <= end_y_d;
				walk_x_q  <= walk_x_d;
				walk_y_q  <= walk_y_d;
				span_x_q  <= span_x_d;
				span_y_q  <= span_y_d;
				neg_x_q   <= neg_x_d;
				neg_y_q   <= neg_y_d;
				err_q     <= err_d;
				drawing_q <= drawing_d;
			end
			if (pop) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rsp_word_q <= rsp_d;
		end
	end

endmodule

// ===== src/vector_command_line_drawer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_command_line_drawer: two-port vector terminal with line walker
// Request channel (req_valid/req_ready/req_word): one bus access or tick per
// word. Response channel (rsp_valid/rsp_ready/rsp_word): exactly one word per
// request, in request order, carrying the status byte, the pixel set by a
// tick and the drawing flag after the request.
// Data port writes 0x59, x0, y0, x1, y1 start a line walk; each tick then
// emits one pixel of a four-connected line, clipped to the screen size.
// A request passes the decode register and the queue before its response is
// registered in the response register; a full queue or a response stall can hold it.
// Throughput: one request per cycle while responses are taken and the queue
// has room; the walk update in the execution stage is combinational.
// A four-entry queue between decode and execution absorbs response stalls;
// when it and the decode register fill, req_ready drops and requests wait.
// Reset clears the command phase, coordinates, walk state and all valids.
// ----------------------------------------------------------------------------
module vector_command_line_drawer
	import vcld_pkg::*;
#(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_word_t req_word,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_word_t rsp_word
);

	q_stat_t     q_stat;
	front_stat_t front_stat;
	logic        push;
	cmd_t        push_cmd;
	logic        pop;
	cmd_t        pop_cmd;

	vcld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_word   (req_word),
		.q_stat     (q_stat),
		.push       (push),
		.push_cmd   (push_cmd),
		.front_stat (front_stat)
	);

	vcld_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.q_stat   (q_stat)
	);

	vcld_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_cmd   (pop_cmd),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_word  (rsp_word)
	);

`ifndef SYNTHESIS
	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(front_stat.valid_s1 && q_stat.full) |-> !req_ready)
		else $error("request taken while decode stage and queue are full");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_word.read_data != STATUS_BUSY)
			|-> (rsp_word.read_data == STATUS_READY && !rsp_word.busy_res))
		else $error("ready status reported while drawing");

	a_pixel_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_word.pixel_valid)
			|-> ({1'b0, rsp_word.pixel_x} < 9'(SCREEN_WIDTH)
				&& {1'b0, rsp_word.pixel_y} < 9'(SCREEN_HEIGHT)
				&& rsp_word.read_data == STATUS_BUSY))
		else $error("pixel emitted outside the screen");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty |-> !pop)
		else $error("command popped from an empty queue");
`endif

endmodule

// ===== test/vcld_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcld_checker: response predictor and scoreboard for the vector line drawer
// Watches both channels. Every accepted request word is run through a local
// model of the command parser and line walker. The predicted response word is
// queued, and each accepted response word is compared field by field against
// the oldest queued prediction.
// ----------------------------------------------------------------------------
module vcld_checker
	import vcld_pkg::*;
#(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_ready,
	input  req_word_t req_word,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  rsp_word_t rsp_word,
	output int        fail_count,
	output int        pending
);

	logic [2:0]        cmd_phase;
	logic [7:0]        start_x, start_y, end_x, end_y;
	logic [7:0]        walk_x, walk_y, span_x, span_y;
	logic              neg_x, neg_y;
	logic signed [9:0] err_term;
	logic              drawing;
	rsp_word_t         predicted_rsp[$];
	rsp_word_t         want;

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name,
				exp_v, act_v);
			fail_count++;
		end
	endtask

	task automatic step_drawer(input req_word_t w, output rsp_word_t r);
		r = '0;
		case (w.req_type)
			REQ_RD_STATUS: r.read_data = drawing ? STATUS_BUSY : STATUS_READY;
			REQ_WR_CTRL: if (!drawing) cmd_phase = 3'd0;
			REQ_WR_DATA: if (!drawing) begin
				case (cmd_phase)
					3'd0: if (w.write_data == OPCODE_VECTOR) cmd_phase = 3'd1;
					3'd1: begin
						start_x = w.write_data;
						cmd_phase = 3'd2;
					end
					3'd2: begin
						start_y = w.write_data;
						cmd_phase = 3'd3;
					end
					3'd3: begin
						end_x = w.write_data;
						cmd_phase = 3'd4;
					end
					3'd4: begin
						end_y = w.write_data;
						cmd_phase = 3'd0;
						walk_x = start_x;
						walk_y = start_y;
						neg_x = end_x < start_x;
						neg_y = end_y < start_y;
						span_x = neg_x ? start_x - end_x : end_x - start_x;
						span_y = neg_y ? start_y - end_y : end_y - start_y;
						err_term = (end_x == start_x) ? -10'sd1 : 10'sd0;
						drawing = 1'b1;
					end
					default: cmd_phase = 3'd0;
				endcase
			end
			REQ_TICK: if (drawing) begin
				if (int'(walk_x) < SCREEN_WIDTH && int'(walk_y) < SCREEN_HEIGHT) begin
					r.pixel_valid = 1'b1;
					r.pixel_x = walk_x;
					r.pixel_y = walk_y;
				end
				if (walk_x == end_x && walk_y == end_y) begin
					drawing = 1'b0;
				end else if (err_term < 0) begin
					walk_y = neg_y ? walk_y - 8'd1 : walk_y + 8'd1;
					err_term = err_term + 10'(span_x);
				end else begin
					walk_x = neg_x ? walk_x - 8'd1 : walk_x + 8'd1;
					err_term = err_term - 10'(span_y);
				end
			end
			default: ;
		endcase
		r.busy_res = drawing;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_phase = '0;
			start_x = '0;
			start_y = '0;
			end_x = '0;
			end_y = '0;
			walk_x = '0;
			walk_y = '0;
			span_x = '0;
			span_y = '0;
			neg_x = 1'b0;
			neg_y = 1'b0;
			err_term = '0;
			drawing = 1'b0;
			predicted_rsp.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (predicted_rsp.size() == 0) begin
					$display("%0t: unexpected response word: expected none, actual %p",
						$time, rsp_word);
					fail_count++;
				end else begin
					want = predicted_rsp.pop_front();
					check_field("read_data", want.read_data, rsp_word.read_data);
					check_field("pixel_valid", 8'(want.pixel_valid), 8'(rsp_word.pixel_valid));
					check_field("pixel_x", want.pixel_x, rsp_word.pixel_x);
					check_field("pixel_y", want.pixel_y, rsp_word.pixel_y);
					check_field("busy_res", 8'(want.busy_res), 8'(rsp_word.busy_res));
				end
			end
			if (req_valid && req_ready) begin
				step_drawer(req_word, want);
				predicted_rsp.push_back(want);
			end
			pending = predicted_rsp.size();
		end
	end

endmodule

// ===== test/tb_vector_command_line_drawer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_command_line_drawer: stimulus and verdict for the line drawer
// Drives a directed set of port accesses and ticks, then random command
// streams: mostly complete vector commands walked to the end by ticks, mixed
// with reads, ignored writes, aborted commands and unused request codes.
// Both channels idle in random bursts; the checker scores every response.
// ----------------------------------------------------------------------------
module tb_vector_command_line_drawer;
	import vcld_pkg::*;

	localparam int STALL_LIMIT = 500;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_word_t req_word = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_word_t rsp_word;
	int        fail_count;
	int        pending;

	bit        idle_on = 1'b1;
	int        item_count = 0;
	int        stall_cycles = 0;
	int        parse_phase = 0;
	int        walk_left = 0;
	logic [7:0] coord[4];

	always #6 clk = ~clk;

	vector_command_line_drawer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_word  (rsp_word)
	);

	vcld_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_word   (req_word),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp_word   (rsp_word),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// track parser and walk length so ticks can finish each line
	task automatic send_word(input logic [2:0] kind, input logic [7:0] data);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		req_word <= '{req_type: kind, write_data: data};
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		item_count++;
		if (kind == REQ_TICK && walk_left > 0) begin
			walk_left--;
		end else if (walk_left == 0) begin
			if (kind == REQ_WR_CTRL) begin
				parse_phase = 0;
			end else if (kind == REQ_WR_DATA) begin
				if (parse_phase == 0) begin
					if (data == OPCODE_VECTOR) parse_phase = 1;
				end else if (parse_phase < 4) begin
					coord[parse_phase - 1] = data;
					parse_phase++;
				end else begin
					coord[3] = data;
					parse_phase = 0;
					walk_left = int'(coord[0] > coord[2] ? coord[0] - coord[2]
							: coord[2] - coord[0])
						+ int'(coord[1] > coord[3] ? coord[1] - coord[3]
							: coord[3] - coord[1]) + 1;
				end
			end
		end
	endtask

	function automatic logic [7:0] near(input int base, input int reach);
		int v;
		v = base + $urandom_range(0, 2 * reach) - reach;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return 8'(v);
	endfunction

	task automatic send_line();
		int         mode;
		logic [7:0] x0, y0, x1, y1;
		mode = $urandom_range(0, 19);
		x0 = 8'($urandom_range(0, 255));
		y0 = 8'($urandom_range(0, 255));
		if (mode == 1 || mode == 2) begin
			x0 = 8'($urandom_range(185, 215));
			y0 = 8'($urandom_range(185, 215));
		end
		x1 = near(x0, 8);
		y1 = near(y0, 8);
		case (mode)
			0: begin
				x1 = 8'($urandom_range(0, 255));
				y1 = 8'($urandom_range(0, 255));
			end
			1, 2: begin
				x1 = near(x0, 12);
				y1 = near(y0, 12);
			end
			3: x1 = x0;
			4: y1 = y0;
			5: begin
				x1 = x0;
				y1 = y0;
			end
			default: ;
		endcase
		send_word(REQ_WR_DATA, OPCODE_VECTOR);
		send_word(REQ_WR_DATA, x0);
		send_word(REQ_WR_DATA, y0);
		send_word(REQ_WR_DATA, x1);
		send_word(REQ_WR_DATA, y1);
	endtask

	// tick the current line to its end, with stray words mixed in
	task automatic finish_walk();
		while (walk_left > 0) begin
			if ($urandom_range(0, 6) == 0)
				send_word(3'($urandom_range(0, 7)), 8'($urandom));
			else
				send_word(REQ_TICK, 8'($urandom));
		end
	endtask

	initial begin
		int kind;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(REQ_RD_STATUS, 8'h00);
		send_word(REQ_RD_DATA, 8'hFF);
		send_word(REQ_TICK, 8'hAA);
		send_word(3'd5, 8'h55);
		send_word(3'd6, 8'hFF);
		send_word(3'd7, 8'h00);
		send_word(REQ_WR_DATA, 8'h00);
		send_word(REQ_WR_CTRL, 8'hFF);
		send_word(REQ_WR_DATA, OPCODE_VECTOR);
		send_word(REQ_WR_DATA, 8'd0);
		send_word(REQ_WR_DATA, 8'd0);
		send_word(REQ_WR_DATA, 8'd0);
		send_word(REQ_WR_DATA, 8'd0);
		send_word(REQ_RD_STATUS, 8'h00);
		send_word(REQ_WR_CTRL, 8'h00);
		send_word(REQ_WR_DATA, OPCODE_VECTOR);
		send_word(REQ_TICK, 8'h00);
		send_word(REQ_WR_DATA, OPCODE_VECTOR);
		send_word(REQ_WR_DATA, 8'd255);
		send_word(REQ_WR_DATA, 8'd255);
		send_word(REQ_WR_DATA, 8'd254);
		send_word(REQ_WR_DATA, 8'd254);
		finish_walk();

		while (item_count < 775) begin
			idle_on = (item_count < 650) && ($urandom_range(0, 3) != 0);
			finish_walk();
			kind = $urandom_range(0, 9);
			if (kind < 2) begin
				repeat ($urandom_range(1, 4))
					send_word(3'($urandom_range(0, 7)), 8'($urandom));
			end else if (kind == 2) begin
				send_word(REQ_WR_CTRL, 8'($urandom));
				send_word(REQ_WR_DATA, OPCODE_VECTOR);
				repeat ($urandom_range(1, 3)) send_word(REQ_WR_DATA, 8'($urandom));
				if ($urandom_range(0, 1) == 0) send_word(REQ_WR_CTRL, 8'($urandom));
				else send_word(REQ_TICK, 8'($urandom));
			end else begin
				if ($urandom_range(0, 9) < 7) send_word(REQ_WR_CTRL, 8'($urandom));
				if ($urandom_range(0, 4) == 0)
					send_word(REQ_WR_DATA, OPCODE_VECTOR ^ 8'($urandom_range(1, 255)));
				send_line();
			end
		end

		req_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 9) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

endmodule
